FILE: design/aeau_pkg.sv
// Shared types, constants and item layouts for the array element address unit.
package aeau_pkg;

	localparam int MAX_ARRAYS = 16;
	localparam int MAX_DIMS   = 8;
	localparam int ID_W       = $clog2(MAX_ARRAYS);
	localparam int DIM_W      = $clog2(MAX_DIMS);
	localparam int DADDR_W    = ID_W + DIM_W;
	localparam int CNT_W      = 4;
	localparam int RANGE_W    = 18;
	localparam int ADDR_W     = 32;

	typedef enum logic [1:0] {
		OP_HEADER = 2'd0,
		OP_BOUNDS = 2'd1,
		OP_INDEX  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAC,
		S_ACC,
		S_SCALE,
		S_ADD
	} state_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [3:0]         array_id;
		logic [30:0]        base_address;
		logic [15:0]        element_size;
		logic [3:0]         dim_count;
		logic [2:0]         dim_number;
		logic signed [15:0] lower_bound;
		logic signed [15:0] upper_bound;
		logic signed [15:0] index_value;
		logic               last_index;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] address;
		logic [3:0]         queried_array;
		logic               count_error;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic mac;
		logic acc_upd;
		logic scale;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] operation;
		logic       last_s1;
		logic       out_busy;
	} status_t;

endpackage

FILE: design/array_element_address_unit_top.sv
// Top level of the array element address unit: controller plus datapath.
//
// Input channel in_valid/in_ready carries one in_item_t per item; output channel
// out_valid/out_ready carries one out_item_t for each subscript item marked last.
// Header (operation 0) and bounds (operation 1) items are written into the
// descriptor memories as they are accepted. A subscript item (operation 2) goes
// through a registered read of the descriptor memories, then a multiply of the
// running offset by the dimension range and an add of the biased subscript.
// The final subscript adds a multiply by element size and the add of the base,
// and its result is then loaded into the output register. A new item can be
// accepted while a subscript that is not the last is being accumulated; after
// the final subscript the input waits until its result is loaded. The input
// side is free again while a finished result waits in the output register; a
// stalled receiver holds the unit only when a second result is ready to be loaded.
// Reset clears the controller, the offset accumulator, the subscript count and
// the output valid; the descriptor memories are not cleared and must be written
// before they are used in a query.
module array_element_address_unit_top import aeau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	cmd_t    cmd;
	status_t status;

	// Sequencer
	aeau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Descriptor storage and address arithmetic
	aeau_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: design/aeau_ctrl.sv
// Controller state machine sequencing descriptor reads, accumulation and scaling.
module aeau_ctrl import aeau_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		in_ready = (state_q == S_IDLE) || (state_q == S_ACC && !status.last_s1);
		accept   = in_valid && in_ready;
		cmd      = '0;
		cmd.take = accept;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && status.operation == OP_INDEX) begin
					state_d = S_MAC;
				end
			end
			S_MAC: begin
				cmd.mac = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc_upd = 1'b1;
				if (status.last_s1) begin
					state_d = S_SCALE;
				end else if (accept && status.operation == OP_INDEX) begin
					state_d = S_MAC;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_ADD;
			end
			S_ADD: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: design/aeau_dp.sv
// Datapath: descriptor memories, offset accumulator, scaling and output register.
module aeau_dp import aeau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  cmd_t      cmd,
	output status_t   status,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int HDR_W = 31 + 16 + 4;
	localparam int DIM_E = 16 + RANGE_W;

	logic [HDR_W-1:0] hdr_mem [MAX_ARRAYS];
	logic [DIM_E-1:0] dim_mem [MAX_ARRAYS*MAX_DIMS];

	logic [HDR_W-1:0] hdr_rd_q;
	logic [DIM_E-1:0] dim_rd_q;

	logic [ID_W-1:0]    id;
	logic               is_hdr;
	logic               is_bnd;
	logic               is_idx;
	logic [DADDR_W-1:0] wr_addr;
	logic [DADDR_W-1:0] rd_addr;
	logic [RANGE_W-1:0] new_range;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_inc;

	logic [15:0]      idx_s1;
	logic             last_s1;
	logic [ID_W-1:0]  id_s1;
	logic [CNT_W-1:0] pos_s1;
	logic [CNT_W-1:0] cnt_s1;

	logic [ADDR_W-1:0] prod_s2;
	logic [ADDR_W-1:0] diff_s2;
	logic              mac_en_s2;
	logic [ADDR_W-1:0] acc_q;
	logic [ADDR_W-1:0] scaled_s3;

	logic [30:0]       rd_base;
	logic [15:0]       rd_size;
	logic [3:0]        rd_dims;
	logic [15:0]       rd_lower;
	logic [RANGE_W-1:0] rd_range;
	logic              mac_en;
	logic              err;

	logic              out_valid_q;
	out_item_t         out_q;

	// Decode the incoming item
	always_comb begin
		id        = in_data.array_id[ID_W-1:0];
		is_hdr    = cmd.take && in_data.operation == OP_HEADER;
		is_bnd    = cmd.take && in_data.operation == OP_BOUNDS
			&& {1'b0, in_data.dim_number} < 4'(MAX_DIMS);
		is_idx    = cmd.take && in_data.operation == OP_INDEX;
		wr_addr   = {id, in_data.dim_number[DIM_W-1:0]};
		rd_addr   = {id, count_q[DIM_W-1:0]};
		new_range = {{2{in_data.upper_bound[15]}}, in_data.upper_bound}
			- {{2{in_data.lower_bound[15]}}, in_data.lower_bound} + RANGE_W'(1);
		count_inc = (count_q == '1) ? count_q : count_q + CNT_W'(1);
	end

	// Header table
	always_ff @(posedge clk) begin
		if (is_hdr) begin
			hdr_mem[id] <= {in_data.base_address, in_data.element_size, in_data.dim_count};
		end
		if (is_idx) begin
			hdr_rd_q <= hdr_mem[id];
		end
	end

	// Dimension table: lower bound and range
	always_ff @(posedge clk) begin
		if (is_bnd) begin
			dim_mem[wr_addr] <= {in_data.lower_bound, new_range};
		end
		if (is_idx) begin
			dim_rd_q <= dim_mem[rd_addr];
		end
	end

	// Subscript counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (is_idx) begin
			count_q <= in_data.last_index ? '0 : count_inc;
		end
	end

	// Hold the subscript item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_s1 <= 1'b0;
		end else if (is_idx) begin
			last_s1 <= in_data.last_index;
		end else if (cmd.load_out) begin
			last_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_idx) begin
			idx_s1 <= in_data.index_value;
			id_s1  <= id;
			pos_s1 <= count_q;
			cnt_s1 <= count_inc;
		end
	end

	always_comb begin
		{rd_base, rd_size, rd_dims} = hdr_rd_q;
		{rd_lower, rd_range}        = dim_rd_q;
		mac_en = pos_s1 < rd_dims && pos_s1 < CNT_W'(MAX_DIMS);
		err    = rd_dims == '0 || rd_dims > 4'(MAX_DIMS) || cnt_s1 != rd_dims;
	end

	// Multiply by the dimension range, form the biased subscript
	always_ff @(posedge clk) begin
		if (cmd.mac) begin
			prod_s2   <= ADDR_W'(acc_q * {{(ADDR_W-RANGE_W){rd_range[RANGE_W-1]}}, rd_range});
			diff_s2   <= {{16{idx_s1[15]}}, idx_s1} - {{16{rd_lower[15]}}, rd_lower};
			mac_en_s2 <= mac_en;
		end
	end

	// Accumulate; clear once the offset has been scaled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.scale) begin
			acc_q <= '0;
		end else if (cmd.acc_upd && mac_en_s2) begin
			acc_q <= prod_s2 + diff_s2;
		end
	end

	// Scale by element size
	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			scaled_s3 <= ADDR_W'(acc_q * {16'd0, rd_size});
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.address       <= err ? '0 : {1'b0, rd_base} + scaled_s3;
			out_q.queried_array <= 4'(id_s1);
			out_q.count_error   <= err;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_data         = out_q;
	assign status.operation = in_data.operation;
	assign status.last_s1   = last_s1;
	assign status.out_busy  = out_valid_q && !out_ready;

endmodule

FILE: tb/tb_array_element_address_unit_top.sv
// Self-checking testbench for the array element address unit: random and directed items.
`timescale 1ns / 1ps

module tb_array_element_address_unit_top;
	import aeau_pkg::*;

	// Operation code that the unit ignores
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Idling phases
	localparam int PH_NONE       = 0;
	localparam int PH_SEND_IDLE  = 1;
	localparam int PH_RECV_STALL = 2;
	localparam int PH_BOTH       = 3;

	localparam int ITEMS_PER_PHASE = 225;

	logic      clk;
	logic      arst_n;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data  = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	array_element_address_unit_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	in_item_t  pending_items[$];
	out_item_t expected_addresses[$];
	logic      in_fire = 1'b0;
	int        mismatch_count = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;

	// Predicted descriptor tables and query state
	bit [31:0] pr_base  [MAX_ARRAYS];
	bit [31:0] pr_size  [MAX_ARRAYS];
	bit [31:0] pr_dims  [MAX_ARRAYS];
	bit [31:0] pr_lower [MAX_ARRAYS*MAX_DIMS];
	bit [31:0] pr_range [MAX_ARRAYS*MAX_DIMS];
	bit [31:0] pr_offset = '0;
	bit [31:0] pr_count  = '0;

	// What the stimulus has written so far, so no unwritten entry is ever read
	bit              hdr_ok   [MAX_ARRAYS];
	bit [3:0]        hdr_dims [MAX_ARRAYS];
	bit [7:0]        bnd_ok   [MAX_ARRAYS];
	bit signed [15:0] gen_lo  [MAX_ARRAYS][MAX_DIMS];
	bit signed [15:0] gen_hi  [MAX_ARRAYS][MAX_DIMS];
	int              gen_pos = 0;
	int              item_count = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit [31:0] widen(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// Apply one item to the predicted state; returns 1 when it yields an address
	function automatic bit predict_address(input in_item_t it, output out_item_t res);
		bit [3:0]  id;
		int        k;
		bit [31:0] dims;
		bit        err;
		res = '0;
		id  = it.array_id;
		if (it.operation == OP_HEADER) begin
			pr_base[id] = {1'b0, it.base_address};
			pr_size[id] = {16'h0, it.element_size};
			pr_dims[id] = {28'h0, it.dim_count};
			return 1'b0;
		end
		if (it.operation == OP_BOUNDS) begin
			k = id * MAX_DIMS + it.dim_number;
			pr_lower[k] = widen(it.lower_bound);
			pr_range[k] = widen(it.upper_bound) - widen(it.lower_bound) + 32'd1;
			return 1'b0;
		end
		if (it.operation != OP_INDEX)
			return 1'b0;
		dims = pr_dims[id];
		// Horner step; subscripts past the dimension count leave the offset alone
		if (pr_count < dims && pr_count < MAX_DIMS) begin
			k = id * MAX_DIMS + pr_count;
			pr_offset = pr_offset * pr_range[k] + (widen(it.index_value) - pr_lower[k]);
		end
		if (pr_count < 15)
			pr_count++;
		if (!it.last_index)
			return 1'b0;
		err = (dims == 0) || (dims > MAX_DIMS) || (pr_count != dims);
		res.address       = err ? 32'h0 : pr_base[id] + pr_size[id] * pr_offset;
		res.queried_array = id;
		res.count_error   = err;
		pr_offset = '0;
		pr_count  = '0;
		return 1'b1;
	endfunction

	function automatic in_item_t random_item();
		logic [127:0] r;
		r = {$urandom, $urandom, $urandom, $urandom};
		return r[$bits(in_item_t)-1:0];
	endfunction

	// Queue an item and track what it writes
	task automatic push_item(input in_item_t it);
		if (it.operation == OP_HEADER) begin
			hdr_ok[it.array_id]   = 1'b1;
			hdr_dims[it.array_id] = it.dim_count;
		end else if (it.operation == OP_BOUNDS) begin
			bnd_ok[it.array_id][it.dim_number] = 1'b1;
			gen_lo[it.array_id][it.dim_number] = it.lower_bound;
			gen_hi[it.array_id][it.dim_number] = it.upper_bound;
		end else if (it.operation == OP_INDEX) begin
			if (it.last_index)
				gen_pos = 0;
			else if (gen_pos < 15)
				gen_pos++;
		end
		if (it.operation != OP_UNUSED)
			item_count++;
		pending_items.push_back(it);
	endtask

	task automatic send_header(input bit [3:0] id, input bit [30:0] base,
			input bit [15:0] size, input bit [3:0] dims);
		in_item_t it;
		it = random_item();
		it.operation    = OP_HEADER;
		it.array_id     = id;
		it.base_address = base;
		it.element_size = size;
		it.dim_count    = dims;
		push_item(it);
	endtask

	task automatic send_bounds(input bit [3:0] id, input bit [2:0] d,
			input bit signed [15:0] lo, input bit signed [15:0] hi);
		in_item_t it;
		it = random_item();
		it.operation   = OP_BOUNDS;
		it.array_id    = id;
		it.dim_number  = d;
		it.lower_bound = lo;
		it.upper_bound = hi;
		push_item(it);
	endtask

	task automatic send_noise();
		in_item_t it;
		it = random_item();
		it.operation = OP_UNUSED;
		push_item(it);
	endtask

	function automatic bit [30:0] rand_base();
		int r;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		return 31'($urandom);
	endfunction

	function automatic bit [15:0] rand_size();
		int r;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		if (r < 60) return 16'($urandom_range(16, 1));
		return 16'($urandom);
	endfunction

	function automatic bit [3:0] rand_dims();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 4'($urandom_range(4, 1));
		if (r < 70) return 4'd8;
		if (r < 80) return 4'($urandom_range(7, 5));
		if (r < 88) return 4'd0;
		return 4'($urandom_range(15, 9));
	endfunction

	task automatic rand_bounds(input bit [3:0] id, input bit [2:0] d);
		bit signed [15:0] lo;
		bit signed [15:0] hi;
		if ($urandom_range(99) < 80) begin
			lo = 16'(int'($urandom_range(40)) - 20);
			hi = lo + 16'($urandom_range(9));
		end else begin
			lo = 16'($urandom);
			hi = 16'($urandom);
		end
		send_bounds(id, d, lo, hi);
	endtask

	// Make sure the next subscript for this array reads only written entries
	task automatic ensure_descr(input bit [3:0] id);
		if (!hdr_ok[id])
			send_header(id, rand_base(), rand_size(), 4'($urandom_range(4, 1)));
		if (gen_pos < MAX_DIMS && !bnd_ok[id][gen_pos])
			rand_bounds(id, 3'(gen_pos));
	endtask

	task automatic send_index(input bit [3:0] id, input bit signed [15:0] idx, input bit last);
		in_item_t it;
		ensure_descr(id);
		it = random_item();
		it.operation   = OP_INDEX;
		it.array_id    = id;
		it.index_value = idx;
		it.last_index  = last;
		push_item(it);
	endtask

	// Mostly an index inside the written bounds, sometimes any value
	function automatic bit signed [15:0] pick_index(input bit [3:0] id);
		int span;
		if (gen_pos < MAX_DIMS && bnd_ok[id][gen_pos] && $urandom_range(9) != 0) begin
			span = int'(gen_hi[id][gen_pos]) - int'(gen_lo[id][gen_pos]);
			if (span >= 0)
				return gen_lo[id][gen_pos] + 16'($urandom_range(span, 0));
		end
		return 16'($urandom);
	endfunction

	task automatic send_query(input bit [3:0] id, input int n, input bit mixed);
		bit [3:0] use_id;
		for (int k = 0; k < n; k++) begin
			use_id = id;
			if (mixed && k != n - 1 && $urandom_range(2) == 0)
				use_id = 4'($urandom_range(15));
			// Slip in descriptor writes to other arrays or ignored items
			if ($urandom_range(99) < 5)
				send_header(4'(id + 4'd1 + $urandom_range(14)), rand_base(), rand_size(),
					rand_dims());
			else if ($urandom_range(99) < 5)
				send_noise();
			ensure_descr(use_id);
			send_index(use_id, pick_index(use_id), k == n - 1);
		end
	endtask

	task automatic directed_items();
		// Largest base and size, eight dimensions, full and negative ranges
		send_header(4'd0, '1, '1, 4'd8);
		send_bounds(4'd0, 3'd0, -16'sd32768, 16'sd32767);
		send_bounds(4'd0, 3'd1, 16'sd32767, -16'sd32768);
		send_index(4'd0, -16'sd32768, 1'b0);
		send_index(4'd0, 16'sd32767, 1'b0);
		for (int k = 2; k < 7; k++)
			send_index(4'd0, 16'($urandom), 1'b0);
		send_noise();
		send_index(4'd0, 16'sd32767, 1'b1);
		// Zero base and size, single dimension
		send_header(4'd15, '0, '0, 4'd1);
		send_index(4'd15, 16'sd0, 1'b1);
		// Dimension count zero and above the maximum
		send_header(4'd3, rand_base(), rand_size(), 4'd0);
		send_index(4'd3, 16'sd5, 1'b1);
		send_header(4'd4, rand_base(), rand_size(), 4'd12);
		send_query(4'd4, 12, 1'b0);
		// Too many subscripts, past the point where the count saturates
		send_query(4'd15, 17, 1'b0);
		// Too few subscripts
		send_query(4'd0, 3, 1'b0);
		// Mixed ids, with a header written mid-query
		send_header(4'd5, 31'h1000, 16'd4, 4'd2);
		send_header(4'd6, 31'h2000, 16'd8, 4'd2);
		send_index(4'd5, 16'sd1, 1'b0);
		send_header(4'd7, rand_base(), rand_size(), 4'd3);
		send_index(4'd6, 16'sd2, 1'b1);
	endtask

	task automatic random_items(input int n);
		int       r;
		int       cnt;
		bit [3:0] id;
		cnt = item_count + n;
		while (item_count < cnt) begin
			r  = $urandom_range(99);
			id = 4'($urandom_range(15));
			if (r < 8) begin
				send_header(id, rand_base(), rand_size(), rand_dims());
			end else if (r < 14) begin
				rand_bounds(id, 3'($urandom_range(7)));
			end else if (r < 17) begin
				send_noise();
			end else if (r < 30) begin
				// Broken query: wrong count or mixed ids
				ensure_descr(id);
				case ($urandom_range(2))
					0: send_query(id, (hdr_dims[id] > 1 && $urandom_range(1) != 0) ?
						int'(hdr_dims[id]) - 1 : int'(hdr_dims[id]) + 1, 1'b0);
					1: send_query(id, int'($urandom_range(16, 1)), 1'b0);
					default: send_query(id, (hdr_dims[id] == 0) ? 1 : int'(hdr_dims[id]),
						1'b1);
				endcase
			end else begin
				if (!hdr_ok[id] || hdr_dims[id] == 0 || hdr_dims[id] > MAX_DIMS)
					send_header(id, rand_base(), rand_size(), 4'($urandom_range(4, 1)));
				send_query(id, int'(hdr_dims[id]), 1'b0);
			end
		end
	endtask

	task automatic drain_inputs();
		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	// Drive inputs at the falling edge; hold an item until it is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (!in_valid || in_fire) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Sample both channels at the rising edge; check results, then predict
	always @(posedge clk) begin : monitor
		out_item_t want;
		out_item_t pred;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (expected_addresses.size() == 0) begin
					$display("%0t: unexpected result address %h array %0d error %0d",
						$time, out_data.address, out_data.queried_array, out_data.count_error);
					mismatch_count++;
				end else begin
					want = expected_addresses.pop_front();
					if (out_data.address !== want.address ||
							out_data.queried_array !== want.queried_array ||
							out_data.count_error !== want.count_error) begin
						$display("%0t: expected address %h array %0d error %0d, got %h %0d %0d",
							$time, want.address, want.queried_array, want.count_error,
							out_data.address, out_data.queried_array, out_data.count_error);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready)
				if (predict_address(in_data, pred))
					expected_addresses.push_back(pred);
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_items();
		for (int ph = PH_NONE; ph <= PH_BOTH; ph++) begin
			send_idle_pct  = (ph == PH_SEND_IDLE) ? 78 : (ph == PH_BOTH) ? 34 : 0;
			recv_stall_pct = (ph == PH_RECV_STALL) ? 78 : (ph == PH_BOTH) ? 34 : 0;
			random_items(ITEMS_PER_PHASE);
			drain_inputs();
		end

		// Let the last results come out, then a few more cycles
		while (expected_addresses.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
